>>> rtl/lfr_pkg.sv
package lfr_pkg;

   localparam logic [7:0] HDR_A = 8'hAA;
   localparam logic [7:0] HDR_B = 8'h55;
   localparam logic [7:0] FTR_A = 8'h0D;
   localparam logic [7:0] FTR_B = 8'h0A;
   localparam logic [7:0] LEN_HEARTBEAT = 8'hFF;
   localparam logic [7:0] LEN_DIRS = 8'd32;
   localparam logic [7:0] LEN_NEAREST = 8'd6;

   localparam int PAY_DEPTH = 32;
   localparam int PAY_AW = $clog2(PAY_DEPTH);

   localparam logic [2:0] BYTES_HEARTBEAT = 3'd1;
   localparam logic [2:0] BYTES_WORD = 3'd4;
   localparam logic [2:0] BYTES_NEAREST = 3'd6;
   localparam logic [2:0] LAST_WORD = 3'd7;

   typedef enum logic [1:0] {
      KIND_HEARTBEAT = 2'd0,
      KIND_DIRS = 2'd1,
      KIND_NEAREST = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      ST_HDR1,
      ST_HDR2,
      ST_LEN,
      ST_PAY,
      ST_CHK,
      ST_FTR1,
      ST_FTR2,
      ST_READ,
      ST_LOAD,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic load_len;
      logic pay_wr;
      logic cnt_err;
      logic cnt_frame;
      logic emit_start;
      logic rd_load;
      logic word_next;
   } cmd_type;

   typedef struct packed {
      logic hdr_a;
      logic hdr_b;
      logic ftr_a;
      logic ftr_b;
      logic len_valid;
      logic pay_last;
      logic chk_ok;
      logic grp_last;
      logic frame_last;
      kind_type kind;
   } sts_type;

endpackage

>>> rtl/lidar_frame_receiver.sv
// Parsing takes one byte per cycle; req_stall stays low while a frame is read in.
// After the closing footer byte, each result has its payload bytes fetched from the
// registered-read payload RAM (a READ and a LOAD state per byte), then it is shown in
// OUT until rsp_stall is low: heartbeat 1 byte, nearest 6, each direction word 4.
// Synchronous active-high reset clears parser state and both counters; payload RAM
// is not cleared.
module lidar_frame_receiver (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_packet_kind,
   output logic [2:0]  rsp_word_index,
   output logic [31:0] rsp_data_word,
   output logic [15:0] rsp_angle_tenths,
   output logic [7:0]  rsp_heartbeat_byte,
   output logic        rsp_last,
   output logic [31:0] rsp_good_frames,
   output logic [31:0] rsp_checksum_errors
);
   import lfr_pkg::*;

   cmd_type cmd;
   sts_type sts;

   lfr_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .rsp_stall(rsp_stall),
      .sts      (sts),
      .cmd      (cmd),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid)
   );

   lfr_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .rx_byte        (req_rx_byte),
      .cmd            (cmd),
      .sts            (sts),
      .packet_kind    (rsp_packet_kind),
      .word_index     (rsp_word_index),
      .data_word      (rsp_data_word),
      .angle_tenths   (rsp_angle_tenths),
      .heartbeat_byte (rsp_heartbeat_byte),
      .good_frames    (rsp_good_frames),
      .checksum_errors(rsp_checksum_errors)
   );

   assign rsp_last = sts.frame_last;

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken while a result is pending");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_packet_kind != KIND_DIRS)) |-> rsp_last)
      else $error("single-result frame without last");

   a_resume: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last) |=> (!req_stall && !rsp_valid))
      else $error("parser did not resume after last beat");

   a_dirs_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last) |=> (!rsp_valid && req_stall))
      else $error("next direction word shown without a RAM fetch");

endmodule

>>> rtl/lfr_ram.sv
module lfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/lfr_dp.sv
module lfr_dp (
   input  logic             clock,
   input  logic             reset,
   input  logic [7:0]       rx_byte,
   input  lfr_pkg::cmd_type cmd,
   output lfr_pkg::sts_type sts,
   output logic [1:0]       packet_kind,
   output logic [2:0]       word_index,
   output logic [31:0]      data_word,
   output logic [15:0]      angle_tenths,
   output logic [7:0]       heartbeat_byte,
   output logic [31:0]      good_frames,
   output logic [31:0]      checksum_errors
);
   import lfr_pkg::*;

   logic [7:0]        length_code_ff, length_code_in;
   logic [5:0]        byte_count_ff, byte_count_in;
   logic [7:0]        running_sum_ff, running_sum_in;
   logic [31:0]       frame_counter_ff, frame_counter_in;
   logic [31:0]       error_counter_ff, error_counter_in;
   logic [PAY_AW-1:0] rd_addr_ff, rd_addr_in;
   logic [2:0]        bytes_left_ff, bytes_left_in;
   logic [2:0]        word_idx_ff, word_idx_in;
   logic [47:0]       shift_ff, shift_in;
   logic [7:0]        rd_data;
   logic [5:0]        count_plus;
   logic [7:0]        expect_sum;
   kind_type          kind;

   lfr_ram #(
      .WIDTH(8),
      .DEPTH(PAY_DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (cmd.pay_wr),
      .wr_addr(byte_count_ff[PAY_AW-1:0]),
      .wr_data(rx_byte),
      .rd_addr(rd_addr_ff),
      .rd_data(rd_data)
   );

   always_comb begin
      priority if (length_code_ff == LEN_HEARTBEAT) begin
         kind = KIND_HEARTBEAT;
      end else if (length_code_ff == LEN_DIRS) begin
         kind = KIND_DIRS;
      end else begin
         kind = KIND_NEAREST;
      end
   end

   assign count_plus = byte_count_ff + 6'd1;
   assign expect_sum = (kind == KIND_HEARTBEAT) ? running_sum_ff + LEN_HEARTBEAT
                                                : running_sum_ff;

   always_comb begin
      sts.hdr_a = (rx_byte == HDR_A);
      sts.hdr_b = (rx_byte == HDR_B);
      sts.ftr_a = (rx_byte == FTR_A);
      sts.ftr_b = (rx_byte == FTR_B);
      sts.len_valid = (rx_byte == LEN_HEARTBEAT) || (rx_byte == LEN_DIRS) ||
                      (rx_byte == LEN_NEAREST);
      sts.pay_last = (kind == KIND_HEARTBEAT) || ({2'b00, count_plus} >= length_code_ff);
      sts.chk_ok = (rx_byte == expect_sum);
      sts.grp_last = (bytes_left_ff == 3'd1);
      sts.frame_last = (kind != KIND_DIRS) || (word_idx_ff == LAST_WORD);
      sts.kind = kind;
   end

   always_comb begin
      length_code_in = length_code_ff;
      byte_count_in = byte_count_ff;
      running_sum_in = running_sum_ff;
      frame_counter_in = frame_counter_ff;
      error_counter_in = error_counter_ff;
      rd_addr_in = rd_addr_ff;
      bytes_left_in = bytes_left_ff;
      word_idx_in = word_idx_ff;
      shift_in = shift_ff;
      if (cmd.load_len) begin
         length_code_in = rx_byte;
         byte_count_in = '0;
         running_sum_in = '0;
      end
      if (cmd.pay_wr) begin
         byte_count_in = count_plus;
         running_sum_in = running_sum_ff + rx_byte;
      end
      if (cmd.cnt_err) begin
         error_counter_in = error_counter_ff + 32'd1;
      end
      if (cmd.cnt_frame) begin
         frame_counter_in = frame_counter_ff + 32'd1;
      end
      if (cmd.emit_start) begin
         rd_addr_in = '0;
         word_idx_in = '0;
         unique case (kind)
            KIND_HEARTBEAT: bytes_left_in = BYTES_HEARTBEAT;
            KIND_DIRS:      bytes_left_in = BYTES_WORD;
            default:        bytes_left_in = BYTES_NEAREST;
         endcase
      end
      if (cmd.rd_load) begin
         shift_in = {rd_data, shift_ff[47:8]};
         rd_addr_in = rd_addr_ff + PAY_AW'(1);
         bytes_left_in = bytes_left_ff - 3'd1;
      end
      if (cmd.word_next) begin
         word_idx_in = word_idx_ff + 3'd1;
         bytes_left_in = BYTES_WORD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_code_ff <= '0;
         byte_count_ff <= '0;
         running_sum_ff <= '0;
         frame_counter_ff <= '0;
         error_counter_ff <= '0;
         rd_addr_ff <= '0;
         bytes_left_ff <= '0;
         word_idx_ff <= '0;
      end else begin
         length_code_ff <= length_code_in;
         byte_count_ff <= byte_count_in;
         running_sum_ff <= running_sum_in;
         frame_counter_ff <= frame_counter_in;
         error_counter_ff <= error_counter_in;
         rd_addr_ff <= rd_addr_in;
         bytes_left_ff <= bytes_left_in;
         word_idx_ff <= word_idx_in;
      end
      shift_ff <= shift_in;
   end

   assign packet_kind = kind;
   assign word_index = (kind == KIND_DIRS) ? word_idx_ff : 3'd0;
   assign data_word = (kind == KIND_HEARTBEAT) ? 32'd0 : shift_ff[47:16];
   assign angle_tenths = (kind == KIND_NEAREST) ? shift_ff[15:0] : 16'd0;
   assign heartbeat_byte = (kind == KIND_HEARTBEAT) ? shift_ff[47:40] : 8'd0;
   assign good_frames = frame_counter_ff;
   assign checksum_errors = error_counter_ff;

endmodule

>>> rtl/lfr_ctrl.sv
module lfr_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             rsp_stall,
   input  lfr_pkg::sts_type sts,
   output lfr_pkg::cmd_type cmd,
   output logic             req_stall,
   output logic             rsp_valid
);
   import lfr_pkg::*;

   state_type state_ff, state_in;
   logic      parsing;
   logic      req_acc;

   assign parsing = (state_ff != ST_READ) && (state_ff != ST_LOAD) && (state_ff != ST_OUT);
   assign req_acc = parsing && req_valid;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_HDR1: if (req_acc) state_in = sts.hdr_a ? ST_HDR2 : ST_HDR1;
         ST_HDR2: if (req_acc) state_in = sts.hdr_b ? ST_LEN : ST_HDR1;
         ST_LEN:  if (req_acc) state_in = sts.len_valid ? ST_PAY : ST_HDR1;
         ST_PAY:  if (req_acc) state_in = sts.pay_last ? ST_CHK : ST_PAY;
         ST_CHK:  if (req_acc) state_in = sts.chk_ok ? ST_FTR1 : ST_HDR1;
         ST_FTR1: if (req_acc) state_in = sts.ftr_a ? ST_FTR2 : ST_HDR1;
         ST_FTR2: if (req_acc) state_in = sts.ftr_b ? ST_READ : ST_HDR1;
         ST_READ: state_in = ST_LOAD;
         ST_LOAD: state_in = sts.grp_last ? ST_OUT : ST_READ;
         ST_OUT: begin
            if (!rsp_stall) begin
               state_in = sts.frame_last ? ST_HDR1 : ST_READ;
            end
         end
         default: state_in = ST_HDR1;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_stall = !parsing;
      rsp_valid = (state_ff == ST_OUT);
      unique case (state_ff)
         ST_LEN:  cmd.load_len = req_acc;
         ST_PAY:  cmd.pay_wr = req_acc;
         ST_CHK:  cmd.cnt_err = req_acc && !sts.chk_ok;
         ST_FTR2: begin
            cmd.emit_start = req_acc && sts.ftr_b;
            cmd.cnt_frame = req_acc && sts.ftr_b && (sts.kind != KIND_HEARTBEAT);
         end
         ST_LOAD: cmd.rd_load = 1'b1;
         ST_OUT:  cmd.word_next = !rsp_stall && !sts.frame_last;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HDR1;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

import lfr_pkg::*;

typedef struct packed {
   kind_type    kind;
   logic [2:0]  index;
   logic [31:0] word;
   logic [15:0] angle;
   logic [7:0]  hb_byte;
   logic        last;
   logic [31:0] frames;
   logic [31:0] errors;
} lidar_beat_type;

typedef enum {FLAW_NONE, FLAW_HDR2, FLAW_LEN, FLAW_CHK, FLAW_FTR1, FLAW_FTR2} frame_flaw_type;

class frame_tracker_type;
   state_type      phase;
   logic [7:0]     len_code;
   logic [5:0]     count;
   logic [7:0]     sum;
   logic [7:0]     payload [32];
   logic [31:0]    frames;
   logic [31:0]    errors;
   lidar_beat_type awaited [$];
   int unsigned    predicted;
   int unsigned    failures;

   function new();
      phase = ST_HDR1;
      len_code = '0;
      count = '0;
      sum = '0;
      frames = '0;
      errors = '0;
      predicted = 0;
      failures = 0;
      foreach (payload[i]) payload[i] = '0;
   endfunction

   function void emit(kind_type kind, logic [2:0] index, logic [31:0] word,
                      logic [15:0] angle, logic [7:0] hb_byte, logic last);
      lidar_beat_type beat;
      beat.kind = kind;
      beat.index = index;
      beat.word = word;
      beat.angle = angle;
      beat.hb_byte = hb_byte;
      beat.last = last;
      beat.frames = frames;
      beat.errors = errors;
      awaited.push_back(beat);
      predicted++;
   endfunction

   function logic [31:0] word_at(int base);
      return {payload[base + 3], payload[base + 2], payload[base + 1], payload[base]};
   endfunction

   function void parse_byte(logic [7:0] b);
      logic [7:0] chk;
      case (phase)
         ST_HDR2: phase = (b == HDR_B) ? ST_LEN : ST_HDR1;
         ST_LEN: begin
            len_code = b;
            count = '0;
            sum = '0;
            if (b == LEN_HEARTBEAT || b == LEN_DIRS || b == LEN_NEAREST)
               phase = ST_PAY;
            else
               phase = ST_HDR1;
         end
         ST_PAY: begin
            payload[count[4:0]] = b;
            sum = sum + b;
            count = count + 6'd1;
            if (len_code == LEN_HEARTBEAT || {2'b00, count} >= len_code)
               phase = ST_CHK;
         end
         ST_CHK: begin
            chk = sum;
            if (len_code == LEN_HEARTBEAT)
               chk = chk + LEN_HEARTBEAT;
            if (b == chk) begin
               phase = ST_FTR1;
            end else begin
               errors = errors + 32'd1;
               phase = ST_HDR1;
            end
         end
         ST_FTR1: phase = (b == FTR_A) ? ST_FTR2 : ST_HDR1;
         ST_FTR2: begin
            if (b == FTR_B) begin
               if (len_code == LEN_HEARTBEAT) begin
                  emit(KIND_HEARTBEAT, 3'd0, '0, '0, payload[0], 1'b1);
               end else if (len_code == LEN_DIRS) begin
                  frames = frames + 32'd1;
                  for (int k = 0; k < 8; k++)
                     emit(KIND_DIRS, 3'(k), word_at(4 * k), '0, '0, k == 7);
               end else begin
                  frames = frames + 32'd1;
                  emit(KIND_NEAREST, 3'd0, word_at(2), {payload[1], payload[0]}, '0, 1'b1);
               end
            end
            phase = ST_HDR1;
         end
         default: phase = (b == HDR_A) ? ST_HDR2 : ST_HDR1;
      endcase
   endfunction

   function string beat_text(lidar_beat_type t);
      return $sformatf("kind=%0d idx=%0d word=%h angle=%h hb=%h last=%b frames=%0d errors=%0d",
                       t.kind, t.index, t.word, t.angle, t.hb_byte, t.last,
                       t.frames, t.errors);
   endfunction

   function void match_beat(lidar_beat_type got);
      lidar_beat_type want;
      if (awaited.size() == 0) begin
         failures++;
         if (failures <= 10)
            $display("%0t unexpected beat: %s", $time, beat_text(got));
         return;
      end
      want = awaited.pop_front();
      if (got.kind !== want.kind || got.index !== want.index || got.word !== want.word ||
          got.angle !== want.angle || got.hb_byte !== want.hb_byte ||
          got.last !== want.last || got.frames !== want.frames ||
          got.errors !== want.errors) begin
         failures++;
         if (failures <= 10) begin
            $display("%0t beat mismatch", $time);
            $display("  expected %s", beat_text(want));
            $display("  actual   %s", beat_text(got));
         end
      end
   endfunction

   function void close_out();
      if (awaited.size() != 0) begin
         failures++;
         $display("%0d beats never arrived", awaited.size());
      end
   endfunction
endclass

module testbench;

   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_CYCLES = 200;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_rx_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_packet_kind;
   logic [2:0]  rsp_word_index;
   logic [31:0] rsp_data_word;
   logic [15:0] rsp_angle_tenths;
   logic [7:0]  rsp_heartbeat_byte;
   logic        rsp_last;
   logic [31:0] rsp_good_frames;
   logic [31:0] rsp_checksum_errors;

   frame_tracker_type tracker = new();
   lidar_beat_type    seen_beat;
   int                send_idle_pct = 0;
   int                stall_pct = 0;
   bit                hold_off = 1'b0;
   int                frame_items = 0;
   int unsigned       quiet_cycles = 0;

   lidar_frame_receiver dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_packet_kind(rsp_packet_kind),
      .rsp_word_index(rsp_word_index),
      .rsp_data_word(rsp_data_word),
      .rsp_angle_tenths(rsp_angle_tenths),
      .rsp_heartbeat_byte(rsp_heartbeat_byte),
      .rsp_last(rsp_last),
      .rsp_good_frames(rsp_good_frames),
      .rsp_checksum_errors(rsp_checksum_errors)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            seen_beat.kind = kind_type'(rsp_packet_kind);
            seen_beat.index = rsp_word_index;
            seen_beat.word = rsp_data_word;
            seen_beat.angle = rsp_angle_tenths;
            seen_beat.hb_byte = rsp_heartbeat_byte;
            seen_beat.last = rsp_last;
            seen_beat.frames = rsp_good_frames;
            seen_beat.errors = rsp_checksum_errors;
            tracker.match_beat(seen_beat);
         end
         if (req_valid && !req_stall)
            tracker.parse_byte(req_rx_byte);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // receiver side; a hold-off request stalls for a long fixed stretch
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off = 1'b0;
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic send_byte(input logic [7:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_frame(input logic [7:0] len, input frame_flaw_type flaw,
                             input bit rand_fill, input logic [7:0] fill);
      logic [7:0] frame [$];
      logic [7:0] sum;
      logic [7:0] b;
      int n;
      n = (len == LEN_HEARTBEAT) ? 1 : (len == LEN_DIRS) ? 32 : (len == LEN_NEAREST) ? 6 : 0;
      sum = (len == LEN_HEARTBEAT) ? LEN_HEARTBEAT : 8'h00;
      frame.push_back(HDR_A);
      b = HDR_B;
      if (flaw == FLAW_HDR2)
         do b = 8'($urandom_range(255)); while (b == HDR_B);
      frame.push_back(b);
      b = len;
      if (flaw == FLAW_LEN)
         do b = 8'($urandom_range(255));
         while (b == LEN_HEARTBEAT || b == LEN_DIRS || b == LEN_NEAREST);
      frame.push_back(b);
      if (n > 0) begin
         for (int i = 0; i < n; i++) begin
            b = rand_fill ? 8'($urandom_range(255)) : fill;
            sum = sum + b;
            frame.push_back(b);
         end
         b = sum;
         if (flaw == FLAW_CHK)
            b = sum ^ 8'($urandom_range(1, 255));
         frame.push_back(b);
         b = FTR_A;
         if (flaw == FLAW_FTR1)
            do b = 8'($urandom_range(255)); while (b == FTR_A);
         frame.push_back(b);
         b = FTR_B;
         if (flaw == FLAW_FTR2)
            do b = 8'($urandom_range(255)); while (b == FTR_B);
         frame.push_back(b);
      end
      foreach (frame[i]) send_byte(frame[i]);
      frame_items += frame.size();
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.awaited.size() != 0) @(posedge clock);
   endtask

   initial begin
      int pick;
      logic [7:0] len;
      frame_flaw_type flaw;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_rx_byte <= 8'h00;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 26;
      stall_pct = 45;

      // bad second header, heartbeats at both byte extremes, unknown length
      send_byte(HDR_A);
      send_byte(8'h54);
      send_frame(LEN_HEARTBEAT, FLAW_NONE, 1'b0, 8'h00);
      send_frame(8'h07, FLAW_NONE, 1'b0, 8'h00);
      send_frame(LEN_HEARTBEAT, FLAW_NONE, 1'b0, 8'hFF);
      frame_items = 0;

      for (int p = 0; p < 3; p++) begin
         send_idle_pct = (p == 0) ? 26 : (p == 1) ? 45 : 0;
         stall_pct = (p == 0) ? 45 : (p == 1) ? 26 : 0;
         while (frame_items < (p + 1) * 77 || (p == 2 && tracker.predicted < 48)) begin
            if ($urandom_range(9) < 3)
               repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
            pick = $urandom_range(9);
            len = (pick < 4) ? LEN_HEARTBEAT : (pick < 7) ? LEN_NEAREST : LEN_DIRS;
            flaw = ($urandom_range(3) == 0) ? frame_flaw_type'($urandom_range(1, 5))
                                            : FLAW_NONE;
            send_frame(len, flaw, 1'b1, 8'h00);
         end
         drain();
         if (p == 0) begin
            // long receiver hold while frames keep coming, to back up the input
            hold_off = 1'b1;
            send_frame(LEN_DIRS, FLAW_NONE, 1'b1, 8'h00);
            send_frame(LEN_NEAREST, FLAW_NONE, 1'b1, 8'h00);
            send_frame(LEN_HEARTBEAT, FLAW_NONE, 1'b1, 8'h00);
            drain();
         end
      end

      repeat (100) @(posedge clock);
      tracker.close_out();
      if (tracker.failures == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
